// ===== rtl/core/hpr_pkg.sv =====
// Shared types, constants and CORDIC angle table for the pose regulator.
package hpr_pkg;

	localparam int CORDIC_STEPS_DEF = 16;

	// datapath widths
	localparam int VW = 37;  // vectoring x/y
	localparam int ZW = 35;  // angle, 2^-30 rad
	localparam int RW = 34;  // rotation x/y, Q30
	localparam int EW = 38;  // gained position error, Q16
	localparam int CW = 28;  // cos/sin, Q24

	localparam logic signed [ZW-1:0] ANG_PI      = 35'sd3373259426;
	localparam logic signed [ZW-1:0] ANG_HALF_PI = 35'sd1686629713;
	localparam logic signed [RW-1:0] CORDIC_K    = 34'sd652032874;

	localparam int TAB_LEN = 30;
	localparam logic [29:0] ATAN_TAB [TAB_LEN] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
		30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
		30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
		30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2
	};

	// configuration register indexes
	typedef enum logic [7:0] {
		REG_GAIN_X        = 8'd0,
		REG_GAIN_Y        = 8'd1,
		REG_GAIN_YAW      = 8'd2,
		REG_ARRIVE_RADIUS = 8'd3
	} reg_idx_t;

	// vectoring cell state
	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} vec_t;

	// rotation cell state
	typedef struct packed {
		logic signed [RW-1:0] x;
		logic signed [RW-1:0] y;
		logic signed [ZW-1:0] z;
	} rot_t;

	// sideband carried past the CORDIC chains
	typedef struct packed {
		logic signed [EW-1:0] ex;
		logic signed [EW-1:0] ey;
		logic                 far;
	} side_t;

endpackage

// ===== rtl/core/hpr_vec_cell.sv =====
// One vectoring CORDIC step with its output register.
module hpr_vec_cell #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          en,
	input  hpr_pkg::vec_t d,
	output hpr_pkg::vec_t q
);

	logic signed [hpr_pkg::VW-1:0] xs, ys;
	logic signed [hpr_pkg::ZW-1:0] ang;
	hpr_pkg::vec_t nxt;

	// y >= 0 turns clockwise
	always_comb begin
		xs  = $signed(d.x) >>> STEP;
		ys  = $signed(d.y) >>> STEP;
		ang = $signed({{(hpr_pkg::ZW-30){1'b0}}, hpr_pkg::ATAN_TAB[STEP]});
		nxt = d;
		if (!d.y[hpr_pkg::VW-1]) begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + ang;
		end else begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - ang;
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nxt;
	end

endmodule

// ===== rtl/core/hpr_rot_cell.sv =====
// One rotation CORDIC step with its output register.
module hpr_rot_cell #(
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          en,
	input  hpr_pkg::rot_t d,
	output hpr_pkg::rot_t q
);

	logic signed [hpr_pkg::RW-1:0] xs, ys;
	logic signed [hpr_pkg::ZW-1:0] ang;
	hpr_pkg::rot_t nxt;

	// drive residual angle toward zero
	always_comb begin
		xs  = $signed(d.x) >>> STEP;
		ys  = $signed(d.y) >>> STEP;
		ang = $signed({{(hpr_pkg::ZW-30){1'b0}}, hpr_pkg::ATAN_TAB[STEP]});
		nxt = d;
		if (!d.z[hpr_pkg::ZW-1]) begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - ang;
		end else begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + ang;
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nxt;
	end

endmodule

// ===== rtl/core/holonomic_pose_regulator_unit.sv =====
// Top level: proportional go-to-pose controller with CORDIC cell chains.
//
// Usage:
//   s_* carries one pose beat (robot and goal pose), m_* returns one command
//   beat per pose: cmd_vx, cmd_vy, cmd_omega in m_tdata, at_target in m_tuser.
//   cfg_* writes the gain and arrive-radius registers; cfg_ready is always high
//   and unknown indexes are dropped. Write only while the pipeline is empty.
// Throughput: one beat per cycle while the output is not stalled; every stage,
//   including each CORDIC cell, holds one item and passes it on as it advances.
// Stall: the whole pipeline advances as one; when m_tvalid is high and
//   m_tready low, every stage holds and s_tready drops the same cycle.
//   A finished result in the output register does not block intake while
//   m_tready is high.
// Reset: arst_n clears all valid bits and restores register defaults
//   (gain_x = gain_y = 0.5, gain_yaw = 1.0, arrive_radius = 3277).
module holonomic_pose_regulator_unit #(
	parameter int CORDIC_STEPS = hpr_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// robot_x, robot_y, robot_qx, robot_qy, robot_qz, robot_qw,
	// goal_x, goal_y, goal_qx, goal_qy, goal_qz, goal_qw
	input  logic [255:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// cmd_vx, cmd_vy, cmd_omega
	output logic [95:0]  m_tdata,
	// at_target
	output logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int VW = hpr_pkg::VW;
	localparam int ZW = hpr_pkg::ZW;
	localparam int EW = hpr_pkg::EW;
	localparam int CW = hpr_pkg::CW;
	localparam int NST  = 2 * CORDIC_STEPS + 8;
	localparam int NSIDE = 2 * CORDIC_STEPS + 2;

	function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
		if (v > 44'sd2147483647) return 32'sh7fffffff;
		else if (v < -44'sd2147483648) return 32'sh80000000;
		else return v[31:0];
	endfunction

	// configuration registers
	logic [15:0] gain_x_q, gain_y_q, gain_yaw_q;
	logic [30:0] radius_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_x_q   <= 16'd2048;
			gain_y_q   <= 16'd2048;
			gain_yaw_q <= 16'd4096;
			radius_q   <= 31'd3277;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hpr_pkg::REG_GAIN_X:        gain_x_q   <= cfg_data[15:0];
				hpr_pkg::REG_GAIN_Y:        gain_y_q   <= cfg_data[15:0];
				hpr_pkg::REG_GAIN_YAW:      gain_yaw_q <= cfg_data[15:0];
				hpr_pkg::REG_ARRIVE_RADIUS: radius_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// global advance and valid line
	logic           en;
	logic [NST-1:0] vld_q;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[NST-2:0], s_tvalid};
	end

	// input fields
	logic signed [31:0] rx, ry, gx, gy;
	logic signed [15:0] q [2][4];  // lane 0 robot, lane 1 goal; x y z w

	always_comb begin
		rx = $signed(s_tdata[31:0]);
		ry = $signed(s_tdata[63:32]);
		gx = $signed(s_tdata[159:128]);
		gy = $signed(s_tdata[191:160]);
		for (int i = 0; i < 4; i++) begin
			q[0][i] = $signed(s_tdata[64 + 16*i +: 16]);
			q[1][i] = $signed(s_tdata[192 + 16*i +: 16]);
		end
	end

	// s1: position errors and quaternion products
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [31:0] zw_s1 [2], xy_s1 [2], yy_s1 [2], zz_s1 [2];

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= 33'(gx) - 33'(rx);
			dy_s1 <= 33'(gy) - 33'(ry);
			for (int l = 0; l < 2; l++) begin
				zw_s1[l] <= q[l][2] * q[l][3];
				xy_s1[l] <= q[l][0] * q[l][1];
				yy_s1[l] <= q[l][1] * q[l][1];
				zz_s1[l] <= q[l][2] * q[l][2];
			end
		end
	end

	// s2: atan2 operands, gained errors, absolute errors
	logic signed [33:0] num_s2 [2], den_s2 [2];
	logic signed [49:0] gxp_s2, gyp_s2;
	logic [32:0]        adx_s2, ady_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				num_s2[l] <= (34'(zw_s1[l]) + 34'(xy_s1[l])) <<< 1;
				den_s2[l] <= 34'sd268435456 - ((34'(yy_s1[l]) + 34'(zz_s1[l])) <<< 1);
			end
			gxp_s2 <= $signed({1'b0, gain_x_q}) * dx_s1;
			gyp_s2 <= $signed({1'b0, gain_y_q}) * dy_s1;
			adx_s2 <= dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
			ady_s2 <= dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
		end
	end

	// s3: vectoring start, rounded errors, arrival squares
	hpr_pkg::vec_t      vinit_s3 [2];
	logic signed [EW-1:0] ex_s3, ey_s3;
	logic [61:0]        sqx_s3, sqy_s3, rsq_s3;
	logic               big_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				vinit_s3[l].zero <= (num_s2[l] == '0) && (den_s2[l] == '0);
				if (den_s2[l][33]) begin
					vinit_s3[l].x <= -VW'(den_s2[l]);
					vinit_s3[l].y <= -VW'(num_s2[l]);
					vinit_s3[l].z <= num_s2[l][33] ? -hpr_pkg::ANG_PI : hpr_pkg::ANG_PI;
				end else begin
					vinit_s3[l].x <= VW'(den_s2[l]);
					vinit_s3[l].y <= VW'(num_s2[l]);
					vinit_s3[l].z <= '0;
				end
			end
			ex_s3  <= EW'((gxp_s2 + 50'sd2048) >>> 12);
			ey_s3  <= EW'((gyp_s2 + 50'sd2048) >>> 12);
			sqx_s3 <= adx_s2[30:0] * adx_s2[30:0];
			sqy_s3 <= ady_s2[30:0] * ady_s2[30:0];
			rsq_s3 <= radius_q * radius_q;
			big_s3 <= (adx_s2 > {2'b00, radius_q}) || (ady_s2 > {2'b00, radius_q});
		end
	end

	// sideband line alongside the cell chains
	hpr_pkg::side_t side_q [NSIDE];

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0].ex  <= ex_s3;
			side_q[0].ey  <= ey_s3;
			side_q[0].far <= big_s3 || ((63'(sqx_s3) + 63'(sqy_s3)) > 63'(rsq_s3));
			for (int j = 1; j < NSIDE; j++) side_q[j] <= side_q[j-1];
		end
	end

	// vectoring chains: yaw of robot and goal
	hpr_pkg::vec_t vchain [2][CORDIC_STEPS+1];

	for (genvar l = 0; l < 2; l++) begin : g_lane
		assign vchain[l][0] = vinit_s3[l];
		for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
			hpr_vec_cell #(.STEP(k)) u_cell (
				.clk (clk),
				.en  (en),
				.d   (vchain[l][k]),
				.q   (vchain[l][k+1])
			);
		end
	end

	// s4: yaw error and rotation start
	logic signed [ZW-1:0] ryaw, gyaw;
	logic signed [20:0]   rq16, gq16;
	logic signed [21:0]   dth_s4;
	hpr_pkg::rot_t        rinit_s4;

	always_comb begin
		ryaw = vchain[0][CORDIC_STEPS].zero ? '0 : vchain[0][CORDIC_STEPS].z;
		gyaw = vchain[1][CORDIC_STEPS].zero ? '0 : vchain[1][CORDIC_STEPS].z;
		rq16 = 21'((ryaw + 35'sd8192) >>> 14);
		gq16 = 21'((gyaw + 35'sd8192) >>> 14);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dth_s4     <= 22'(gq16) - 22'(rq16);
			rinit_s4.y <= '0;
			if (ryaw > hpr_pkg::ANG_HALF_PI) begin
				rinit_s4.z <= ryaw - hpr_pkg::ANG_PI;
				rinit_s4.x <= -hpr_pkg::CORDIC_K;
			end else if (ryaw < -hpr_pkg::ANG_HALF_PI) begin
				rinit_s4.z <= ryaw + hpr_pkg::ANG_PI;
				rinit_s4.x <= -hpr_pkg::CORDIC_K;
			end else begin
				rinit_s4.z <= ryaw;
				rinit_s4.x <= hpr_pkg::CORDIC_K;
			end
		end
	end

	// rotation chain: cos and sin of robot yaw
	hpr_pkg::rot_t rchain [CORDIC_STEPS+1];

	assign rchain[0] = rinit_s4;
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
		hpr_rot_cell #(.STEP(k)) u_cell (
			.clk (clk),
			.en  (en),
			.d   (rchain[k]),
			.q   (rchain[k+1])
		);
	end

	// dth waits in step with the rotation chain
	logic signed [21:0] dth_q [CORDIC_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			dth_q[0] <= dth_s4;
			for (int j = 1; j < CORDIC_STEPS; j++) dth_q[j] <= dth_q[j-1];
		end
	end

	// s5: cos/sin to Q24, yaw product
	logic signed [CW-1:0] c_s5, s_s5;
	logic signed [38:0]   omp_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s5   <= CW'((rchain[CORDIC_STEPS].x + 34'sd32) >>> 6);
			s_s5   <= CW'((rchain[CORDIC_STEPS].y + 34'sd32) >>> 6);
			omp_s5 <= $signed({1'b0, gain_yaw_q}) * dth_q[CORDIC_STEPS-1];
		end
	end

	// s6: split products of the frame rotation
	hpr_pkg::side_t     sd5;
	logic signed [18:0] exh, eyh;
	logic signed [19:0] exl, eyl;
	logic signed [46:0] hxc_s6, hys_s6, hyc_s6, hxs_s6;
	logic signed [47:0] lxc_s6, lys_s6, lyc_s6, lxs_s6;
	logic signed [27:0] om_s6;
	logic               far_s6;

	always_comb begin
		sd5 = side_q[NSIDE-1];
		exh = sd5.ex[EW-1:19];
		eyh = sd5.ey[EW-1:19];
		exl = $signed({1'b0, sd5.ex[18:0]});
		eyl = $signed({1'b0, sd5.ey[18:0]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hxc_s6 <= exh * c_s5;
			hys_s6 <= eyh * s_s5;
			hyc_s6 <= eyh * c_s5;
			hxs_s6 <= exh * s_s5;
			lxc_s6 <= exl * c_s5;
			lys_s6 <= eyl * s_s5;
			lyc_s6 <= eyl * c_s5;
			lxs_s6 <= exl * s_s5;
			om_s6  <= 28'((omp_s5 + 39'sd2048) >>> 12);
			far_s6 <= sd5.far;
		end
	end

	// s7: recombine partial products
	logic signed [67:0] vxs_s7, vys_s7;
	logic signed [27:0] om_s7;
	logic               far_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			vxs_s7 <= ((68'(hxc_s6) + 68'(hys_s6)) <<< 19) + 68'(lxc_s6) + 68'(lys_s6);
			vys_s7 <= ((68'(hyc_s6) - 68'(hxs_s6)) <<< 19) + 68'(lyc_s6) - 68'(lxs_s6);
			om_s7  <= om_s6;
			far_s7 <= far_s6;
		end
	end

	// s8: round, saturate, arrival override
	logic signed [43:0] vxr, vyr;

	always_comb begin
		vxr = 44'((vxs_s7 + 68'sd8388608) >>> 24);
		vyr = 44'((vys_s7 + 68'sd8388608) >>> 24);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (far_s7) begin
				m_tdata[31:0]  <= sat32(vxr);
				m_tdata[63:32] <= sat32(vyr);
				m_tdata[95:64] <= sat32(44'(om_s7));
			end else begin
				m_tdata <= '0;
			end
			m_tuser[0] <= !far_s7;
		end
	end

endmodule

// ===== rtl/core/hpr_checker.sv =====
// Port-level checks for the pose regulator, bound to the top level.
module hpr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        cfg_ready
);

	// a stalled output beat stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat dropped or changed while stalled");

	// intake only stops behind a stalled output beat
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// arrival forces all commands to zero
	a_arrive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("nonzero command with at_target set");

	// configuration channel never stalls
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind holonomic_pose_regulator_unit hpr_checker u_hpr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser),
	.cfg_ready (cfg_ready)
);

// ===== sim/tb.sv =====
// Self-checking testbench for the holonomic pose regulator unit.
`timescale 1ns / 1ps

module tb;

	localparam int STEPS = hpr_pkg::CORDIC_STEPS_DEF;
	localparam int LAT = 2 * STEPS + 8;
	localparam longint LIMIT = 400000;

	typedef struct {
		logic signed [31:0] rx, ry, gx, gy;
		logic signed [15:0] rq [4];
		logic signed [15:0] gq [4];
	} pose_t;

	typedef struct {
		logic [31:0] vx, vy, om;
		logic        at;
	} cmd_t;

	logic         clk, arst_n;
	logic         s_tvalid, s_tready;
	logic [255:0] s_tdata;
	logic         m_tvalid, m_tready;
	logic [95:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_valid, cfg_ready;
	logic [7:0]   cfg_index;
	logic [31:0]  cfg_data;

	holonomic_pose_regulator_unit uut (.*);

	// predictor copy of the registers
	longint g_x, g_y, g_yaw, radius;

	pose_t pending_poses [$];
	cmd_t  expected_cmds [$];
	int    mismatches = 0;
	bit    steady = 0;      // no-idle stretch
	longint cycle = 0;

	function automatic longint asr(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint rnd(longint v, int k);
		return (v + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// yaw in 2^-30 rad from a quaternion, vectoring CORDIC
	function automatic longint quat_to_yaw(longint qx, longint qy, longint qz, longint qw);
		longint num, den, x, y, z, xs, ys;
		num = 2 * (qz * qw + qx * qy);
		den = (longint'(1) << 28) - 2 * (qy * qy + qz * qz);
		x = den; y = num; z = 0;
		if (num == 0 && den == 0) return 0;
		if (x < 0) begin
			x = -x; y = -y;
			z = (num >= 0) ? longint'(hpr_pkg::ANG_PI) : -longint'(hpr_pkg::ANG_PI);
		end
		for (int i = 0; i < STEPS && i < hpr_pkg::TAB_LEN; i++) begin
			xs = asr(x, i); ys = asr(y, i);
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += longint'(hpr_pkg::ATAN_TAB[i]);
			end else begin
				x = x - ys; y = y + xs; z -= longint'(hpr_pkg::ATAN_TAB[i]);
			end
		end
		return z;
	endfunction

	// cos and sin in Q24, rotation CORDIC
	function automatic void yaw_to_cos_sin(input longint zin, output longint c,
			output longint s);
		longint x, y, z, xs, ys;
		x = longint'(hpr_pkg::CORDIC_K); y = 0; z = zin;
		if (z > longint'(hpr_pkg::ANG_HALF_PI)) begin
			z -= longint'(hpr_pkg::ANG_PI); x = -x;
		end else if (z < -longint'(hpr_pkg::ANG_HALF_PI)) begin
			z += longint'(hpr_pkg::ANG_PI); x = -x;
		end
		for (int i = 0; i < STEPS && i < hpr_pkg::TAB_LEN; i++) begin
			xs = asr(x, i); ys = asr(y, i);
			if (z >= 0) begin
				x = x - ys; y = y + xs; z -= longint'(hpr_pkg::ATAN_TAB[i]);
			end else begin
				x = x + ys; y = y - xs; z += longint'(hpr_pkg::ATAN_TAB[i]);
			end
		end
		c = rnd(x, 6); s = rnd(y, 6);
	endfunction

	function automatic cmd_t predict_cmd(pose_t p);
		cmd_t r;
		longint dx, dy, adx, ady, ryaw, gyaw, c, s, ex, ey, dth;
		bit far;
		dx = longint'(p.gx) - longint'(p.rx);
		dy = longint'(p.gy) - longint'(p.ry);
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		if (adx > radius || ady > radius) far = 1;
		else far = adx * adx + ady * ady > radius * radius;
		r.vx = 0; r.vy = 0; r.om = 0; r.at = !far;
		if (far) begin
			ryaw = quat_to_yaw(p.rq[0], p.rq[1], p.rq[2], p.rq[3]);
			gyaw = quat_to_yaw(p.gq[0], p.gq[1], p.gq[2], p.gq[3]);
			ex = rnd(g_x * dx, 12);
			ey = rnd(g_y * dy, 12);
			dth = rnd(gyaw, 14) - rnd(ryaw, 14);
			yaw_to_cos_sin(ryaw, c, s);
			r.vx = 32'(sat32(rnd(ex * c + ey * s, 24)));
			r.vy = 32'(sat32(rnd(ey * c - ex * s, 24)));
			r.om = 32'(sat32(rnd(g_yaw * dth, 12)));
		end
		return r;
	endfunction

	function automatic logic [255:0] pack_pose(pose_t p);
		return {p.gq[3], p.gq[2], p.gq[1], p.gq[0], p.gy, p.gx,
			p.rq[3], p.rq[2], p.rq[1], p.rq[0], p.ry, p.rx};
	endfunction

	// quaternion component: mostly in range, with the extremes
	function automatic logic signed [15:0] rand_q();
		case ($urandom_range(9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'($urandom);
			3: return 16'sd0;
			default: return 16'($urandom_range(32768) - 16384);
		endcase
	endfunction

	function automatic logic signed [31:0] rand_pos();
		case ($urandom_range(5))
			0: return 32'($urandom);
			1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($urandom_range(2000000) - 1000000);
		endcase
	endfunction

	function automatic pose_t rand_pose();
		pose_t p;
		p.rx = rand_pos(); p.ry = rand_pos();
		for (int i = 0; i < 4; i++) begin
			p.rq[i] = rand_q(); p.gq[i] = rand_q();
		end
		// near-goal cases straddle the arrive radius
		if ($urandom_range(4) == 0) begin
			p.gx = p.rx + 32'($urandom_range(8000) - 4000);
			p.gy = p.ry + 32'($urandom_range(8000) - 4000);
		end else begin
			p.gx = rand_pos(); p.gy = rand_pos();
		end
		return p;
	endfunction

	function automatic pose_t make_pose(int rx, int ry, int gx, int gy,
			int q0, int q1, int q2, int q3);
		pose_t p;
		p.rx = rx; p.ry = ry; p.gx = gx; p.gy = gy;
		p.rq = '{16'(q0), 16'(q1), 16'(q2), 16'(q3)};
		p.gq = '{16'(q3), 16'(q2), 16'(q1), 16'(q0)};
		return p;
	endfunction

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// pose driver
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			expected_cmds.push_back(predict_cmd(pending_poses.pop_front()));
		end
		if ((!s_tvalid || s_tready) && arst_n && !cfg_valid) begin
			if (pending_poses.size() > 0 && (steady || $urandom_range(99) >= 36)) begin
				s_tvalid <= 1'b1;
				s_tdata <= pack_pose(pending_poses[0]);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// command monitor and backpressure
	always @(posedge clk) begin
		cycle++;
		if (m_tvalid && m_tready) begin
			if (expected_cmds.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected command beat %h", m_tdata);
			end else begin
				cmd_t e;
				e = expected_cmds.pop_front();
				if (m_tdata[31:0] !== e.vx || m_tdata[63:32] !== e.vy ||
						m_tdata[95:64] !== e.om || m_tuser[0] !== e.at) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp vx %h vy %h om %h at %b, got %h %h %h %b",
							e.vx, e.vy, e.om, e.at, m_tdata[31:0], m_tdata[63:32],
							m_tdata[95:64], m_tuser[0]);
				end
			end
		end
		if (arst_n) m_tready <= steady || $urandom_range(99) >= 36;
		if (cycle > LIMIT) begin
			$display("holonomic_pose_regulator_unit test failed");
			$finish;
		end
	end

	task automatic write_reg(hpr_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			hpr_pkg::REG_GAIN_X: g_x = val[15:0];
			hpr_pkg::REG_GAIN_Y: g_y = val[15:0];
			hpr_pkg::REG_GAIN_YAW: g_yaw = val[15:0];
			hpr_pkg::REG_ARRIVE_RADIUS: radius = val[30:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (pending_poses.size() == 0 && !s_tvalid && expected_cmds.size() == 0);
		repeat (LAT + 4) @(posedge clk);
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) pending_poses.push_back(rand_pose());
		drain();
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0; s_tdata = '0; m_tready = 0;
		cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		g_x = 2048; g_y = 2048; g_yaw = 4096; radius = 3277;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: defaults, arrival edge, zero quaternion, extremes
		pending_poses.push_back(make_pose(0, 0, 0, 0, 0, 0, 0, 16384));
		pending_poses.push_back(make_pose(0, 0, 3277, 0, 0, 0, 0, 16384));
		pending_poses.push_back(make_pose(0, 0, 3278, 0, 0, 0, 0, 16384));
		pending_poses.push_back(make_pose(0, 0, 2318, 2318, 0, 0, 0, 16384));
		pending_poses.push_back(make_pose(0, 0, 2317, 2317, 0, 0, 0, 16384));
		pending_poses.push_back(make_pose(0, 0, 65536, 65536, 0, 0, 0, 0));
		pending_poses.push_back(make_pose(0, 0, 65536, 0, 0, 0, 16384, 0));
		pending_poses.push_back(make_pose(0, 0, 65536, 0, 0, 0, -16384, 0));
		pending_poses.push_back(make_pose(0, 0, 65536, -65536, 0, 0, 11585, 11585));
		pending_poses.push_back(make_pose(0, 0, 65536, 65536, 0, 0, 11585, -11585));
		pending_poses.push_back(make_pose(0, 0, 65536, 65536, 16384, 16384, 16384, 16384));
		pending_poses.push_back(make_pose(32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h80000000, -16384, -16384, -16384, -16384));
		pending_poses.push_back(make_pose(32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff, 16384, -16384, 16384, -16384));
		pending_poses.push_back(make_pose(0, 0, -65536, 65536, 0, 16384, 0, 0));
		drain();

		// maximum gains, maximum radius
		write_reg(hpr_pkg::REG_GAIN_X, 32'hffff);
		write_reg(hpr_pkg::REG_GAIN_Y, 32'hffff);
		write_reg(hpr_pkg::REG_GAIN_YAW, 32'hffff);
		write_reg(hpr_pkg::REG_ARRIVE_RADIUS, 32'h7fffffff);
		pending_poses.push_back(make_pose(32'h7fffffff, 0, 32'h80000000, 0, 0, 0, 16384, 1));
		pending_poses.push_back(make_pose(0, 32'h80000000, 0, 32'h7fffffff, 0, 0, 16384, 1));
		run_random(60);

		// zero gains, zero radius, out-of-range index ignored
		write_reg(hpr_pkg::REG_GAIN_X, 32'h0);
		write_reg(hpr_pkg::REG_GAIN_Y, 32'h0);
		write_reg(hpr_pkg::REG_GAIN_YAW, 32'h0);
		write_reg(hpr_pkg::REG_ARRIVE_RADIUS, 32'h0);
		write_reg(hpr_pkg::reg_idx_t'(8'd7), 32'h1234);
		pending_poses.push_back(make_pose(5, 5, 5, 5, 0, 0, 0, 16384));
		run_random(60);

		// random settings, then a long run with no idling
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(hpr_pkg::REG_GAIN_X, $urandom_range(65535));
			write_reg(hpr_pkg::REG_GAIN_Y, $urandom_range(65535));
			write_reg(hpr_pkg::REG_GAIN_YAW, $urandom_range(65535));
			write_reg(hpr_pkg::REG_ARRIVE_RADIUS, ph[0] ? $urandom : $urandom_range(6000));
			if (ph == 3) steady = 1;
			run_random(ph == 3 ? 250 : 130);
			steady = 0;
		end
		write_reg(hpr_pkg::REG_GAIN_X, 2048);
		write_reg(hpr_pkg::REG_ARRIVE_RADIUS, 3277);
		run_random(40);

		if (mismatches == 0 && expected_cmds.size() == 0)
			$display("holonomic_pose_regulator_unit test passed");
		else
			$display("holonomic_pose_regulator_unit test failed");
		$finish;
	end

endmodule
